/* sv/websocket_frame_deframer_top_defines.svh */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_defines.svh
// Assertion macros for the frame deframer. They compile to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// concurrent check on the module's own clk and arst_n
`define WSDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// concurrent check with an explicit clock and active-low reset
`define WSDF_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

`else

`define WSDF_ASSERT(lbl, prop, msg)
`define WSDF_ASSERT_CLK(lbl, ck, rstn, prop, msg)

`endif

`endif

/* sv/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants of the frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	// payload length counter width (16 to 64)
	localparam int LEN_BITS = 64;

	// header parse phases
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// opcodes
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	// result kinds
	localparam logic [2:0] KIND_DATA       = 3'd0;
	localparam logic [2:0] KIND_END        = 3'd1;
	localparam logic [2:0] KIND_PING       = 3'd2;
	localparam logic [2:0] KIND_PING_EMPTY = 3'd3;
	localparam logic [2:0] KIND_CLOSE      = 3'd4;

	// 7-bit length codes and header byte counts
	localparam logic [6:0] LEN7_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN7_EXT16     = 7'd126;
	localparam logic [3:0] EXT16_BYTES    = 4'd2;
	localparam logic [3:0] EXT64_BYTES    = 4'd8;
	localparam logic [2:0] KEY_BYTES      = 3'd4;

endpackage

/* sv/websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side frame parser: header, extended length, mask key, payload.
// Usage:
//   rx channel (rx_valid/rx_stall, rx_byte) takes one stream byte per request.
//   res channel (res_valid/res_stall) returns data_byte, kind, msg_type, last.
//   cfg_we/cfg_data write the enable bit; bytes are dropped while it is low.
//   Mask key bytes are consumed but not applied. A close frame yields a close
//   event after its header, then all input is dropped until reset.
// Timing: a byte is registered on accept and parsed once the result slot is
//   free or drains; its result (if any) is registered in the result register.
//   One byte per cycle is sustained while res_stall is low; the 64-bit length
//   decrement/zero test in the parse stage is the longest path.
// Reset: arst_n clears enable, the parser (first header byte), the message
//   type and the closed flag; both channels come up empty.
// Stall: while res_stall holds a waiting result, the input register fills and
//   rx_stall rises; nothing is dropped or reordered.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top
	import wsdf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] data_byte,
	output logic [2:0] kind,
	output logic [1:0] msg_type,
	output logic       last
);

	// configuration
	logic enable_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t              phase_q, phase_nxt;
	logic                fin_q, fin_nxt;
	logic [3:0]          opcode_q, opcode_nxt;
	logic                mask_q, mask_nxt;
	logic [3:0]          lbl_q, lbl_nxt;
	logic [2:0]          kbl_q, kbl_nxt;
	logic [LEN_BITS-1:0] pl_q, pl_nxt;
	logic [1:0]          mtype_q, mtype_nxt;
	logic                closed_q, closed_nxt;

	// result register
	logic       res_valid_q;
	logic [7:0] data_q;
	logic [2:0] kind_q;
	logic [1:0] mtype_out_q;
	logic       last_q;

	// parse-stage helpers
	logic                adv, proc;
	logic [6:0]          len7;
	logic [LEN_BITS-1:0] pl_shift, pl_dec, len_cand;
	logic [3:0]          lbl_dec;
	logic [2:0]          kbl_dec;
	logic                len_zero, pl_final, hdr_done;
	logic                emit;
	logic [7:0]          data_c;
	logic [2:0]          kind_c;
	logic                last_c;

	// handshake: the parse stage moves when the result slot is free or drains
	assign adv      = !res_valid_q || !res_stall;
	assign proc     = valid_s1 && adv && enable_q && !closed_q;
	assign rx_stall = valid_s1 && !adv;

	// datapath helpers
	assign len7     = byte_s1[6:0];
	assign pl_shift = {pl_q[LEN_BITS-9:0], byte_s1};
	assign pl_dec   = pl_q - {{(LEN_BITS-1){1'b0}}, 1'b1};
	assign pl_final = (pl_dec == '0);
	assign lbl_dec  = lbl_q - 4'd1;
	assign kbl_dec  = kbl_q - 3'd1;

	// payload length as seen when the header completes on this byte
	always_comb begin
		case (phase_q)
			PH_HDR1:   len_cand = {{(LEN_BITS-7){1'b0}}, len7};
			PH_EXTLEN: len_cand = pl_shift;
			default:   len_cand = pl_q;
		endcase
	end
	assign len_zero = (len_cand == '0);

	// header complete on this byte
	always_comb begin
		case (phase_q)
			PH_HDR1:   hdr_done = (len7 <= LEN7_SHORT_MAX) && !byte_s1[7];
			PH_EXTLEN: hdr_done = (lbl_dec == 4'd0) && !mask_q;
			PH_KEY:    hdr_done = (kbl_dec == 3'd0);
			default:   hdr_done = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		phase_nxt  = phase_q;
		fin_nxt    = fin_q;
		opcode_nxt = opcode_q;
		mask_nxt   = mask_q;
		lbl_nxt    = lbl_q;
		kbl_nxt    = kbl_q;
		pl_nxt     = pl_q;
		mtype_nxt  = mtype_q;
		closed_nxt = closed_q;
		if (proc) begin
			case (phase_q)
				PH_HDR1: begin
					mask_nxt = byte_s1[7];
					if (len7 <= LEN7_SHORT_MAX) begin
						pl_nxt  = {{(LEN_BITS-7){1'b0}}, len7};
						lbl_nxt = 4'd0;
						if (byte_s1[7]) begin
							kbl_nxt   = KEY_BYTES;
							phase_nxt = PH_KEY;
						end
					end else begin
						pl_nxt    = '0;
						lbl_nxt   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
						phase_nxt = PH_EXTLEN;
					end
				end
				PH_EXTLEN: begin
					pl_nxt  = pl_shift;
					lbl_nxt = lbl_dec;
					if (lbl_dec == 4'd0 && mask_q) begin
						kbl_nxt   = KEY_BYTES;
						phase_nxt = PH_KEY;
					end
				end
				PH_KEY: begin
					kbl_nxt = kbl_dec;
				end
				PH_PAYLOAD: begin
					pl_nxt = pl_dec;
					if (pl_final) begin
						phase_nxt = PH_HDR0;
					end
				end
				default: begin
					fin_nxt    = byte_s1[7];
					opcode_nxt = byte_s1[3:0];
					phase_nxt  = PH_HDR1;
				end
			endcase
			// frame decision once the header is in
			if (hdr_done) begin
				if (opcode_q == OP_CLOSE) begin
					closed_nxt = 1'b1;
					phase_nxt  = PH_HDR0;
				end else begin
					if (opcode_q == OP_TEXT || opcode_q == OP_BINARY) begin
						mtype_nxt = opcode_q[1:0];
					end
					phase_nxt = len_zero ? PH_HDR0 : PH_PAYLOAD;
				end
			end
		end
	end

	// result decode
	always_comb begin
		emit   = 1'b0;
		data_c = 8'd0;
		kind_c = KIND_DATA;
		last_c = 1'b0;
		if (proc) begin
			if (hdr_done) begin
				if (opcode_q == OP_CLOSE) begin
					emit   = 1'b1;
					kind_c = KIND_CLOSE;
				end else if (opcode_q == OP_PING) begin
					emit   = len_zero;
					kind_c = KIND_PING_EMPTY;
					last_c = 1'b1;
				end else begin
					emit   = len_zero && fin_q;
					kind_c = KIND_END;
					last_c = 1'b1;
				end
			end else if (phase_q == PH_PAYLOAD) begin
				emit   = 1'b1;
				data_c = byte_s1;
				if (opcode_q == OP_PING) begin
					kind_c = KIND_PING;
					last_c = pl_final;
				end else begin
					kind_c = KIND_DATA;
					last_c = pl_final && fin_q;
				end
			end
		end
	end

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			lbl_q    <= 4'd0;
			kbl_q    <= 3'd0;
			pl_q     <= '0;
			mtype_q  <= 2'd0;
			closed_q <= 1'b0;
		end else begin
			phase_q  <= phase_nxt;
			fin_q    <= fin_nxt;
			opcode_q <= opcode_nxt;
			mask_q   <= mask_nxt;
			lbl_q    <= lbl_nxt;
			kbl_q    <= kbl_nxt;
			pl_q     <= pl_nxt;
			mtype_q  <= mtype_nxt;
			closed_q <= closed_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			data_q      <= data_c;
			kind_q      <= kind_c;
			mtype_out_q <= mtype_nxt;
			last_q      <= last_c;
		end
	end

	assign res_valid = res_valid_q;
	assign data_byte = data_q;
	assign kind      = kind_q;
	assign msg_type  = mtype_out_q;
	assign last      = last_q;

	// checks
	`WSDF_ASSERT(a_closed_sticky, closed_q |=> closed_q, "closed flag dropped")
	`WSDF_ASSERT(a_close_event, $rose(closed_q) |-> (res_valid_q && kind_q == KIND_CLOSE),
		"close without close event")
	`WSDF_ASSERT(a_close_fields,
		(res_valid_q && kind_q == KIND_CLOSE) |-> (data_q == 8'd0 && !last_q),
		"close event with data or last")
	`WSDF_ASSERT(a_payload_nonzero, (phase_q == PH_PAYLOAD) |-> (pl_q != '0),
		"payload phase with zero bytes left")
	`WSDF_ASSERT_CLK(a_key_masked, clk, arst_n, (phase_q == PH_KEY) |-> mask_q,
		"key phase without mask bit")

endmodule

/* tb/websocket_frame_deframer_top_test.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_test
// Self-checking bench for the receive-side frame deframer. A clocked driver
// feeds stream bytes from a pending queue and runs a cycle-free parser model
// on every accepted request. A clocked monitor checks each result against the
// oldest predicted event. Stimulus covers directed header forms, a mid-frame
// disable, a long random frame mix, and a closing frame followed by dropped input.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_test;
	import wsdf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// opcodes and length code not named in the package
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_PONG = 4'hA;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef enum int {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
		logic [1:0] mtype;
		logic       last;
	} deframe_event_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_data = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] data_byte;
	logic [2:0] kind;
	logic [1:0] msg_type;
	logic       last;

	logic [7:0]     rx_pending[$];
	deframe_event_t due_events[$];
	deframe_event_t want;
	deframe_event_t got;
	int             errors = 0;
	int             queued_bytes = 0;
	bit             steady = 1'b0;

	// parser model state
	logic                link_enabled = 1'b0;
	phase_t              ph = PH_HDR0;
	logic                fin = 1'b0;
	logic [3:0]          opc = '0;
	logic                masked = 1'b0;
	logic [3:0]          len_left = '0;
	logic [2:0]          key_left = '0;
	logic [LEN_BITS-1:0] remaining = '0;
	logic [1:0]          mtype = '0;
	logic                closed_seen = 1'b0;

	websocket_frame_deframer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.data_byte(data_byte),
		.kind     (kind),
		.msg_type (msg_type),
		.last     (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------
	task automatic note_event(input logic [7:0] d, input logic [2:0] k, input logic l);
		deframe_event_t ev;
		ev = '{data: d, kind: k, mtype: mtype, last: l};
		due_events.insert(due_events.size(), ev);
	endtask

	// header complete: decide what the frame does
	task automatic header_known();
		if (opc == OP_CLOSE) begin
			closed_seen = 1'b1;
			ph = PH_HDR0;
			note_event(8'h00, KIND_CLOSE, 1'b0);
		end else if (opc == OP_PING) begin
			if (remaining == '0) begin
				ph = PH_HDR0;
				note_event(8'h00, KIND_PING_EMPTY, 1'b1);
			end else begin
				ph = PH_PAYLOAD;
			end
		end else begin
			if (opc == OP_TEXT || opc == OP_BINARY)
				mtype = opc[1:0];
			if (remaining == '0) begin
				ph = PH_HDR0;
				if (fin)
					note_event(8'h00, KIND_END, 1'b1);
			end else begin
				ph = PH_PAYLOAD;
			end
		end
	endtask

	// length known: mask key next, or header done
	task automatic length_known();
		if (masked) begin
			key_left = KEY_BYTES;
			ph = PH_KEY;
		end else begin
			header_known();
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		logic final_byte;
		if (link_enabled && !closed_seen) begin
			case (ph)
			PH_HDR1: begin
				masked = b[7];
				if (b[6:0] <= LEN7_SHORT_MAX) begin
					remaining = LEN_BITS'(b[6:0]);
					len_left = '0;
					length_known();
				end else begin
					remaining = '0;
					len_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					ph = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				remaining = (remaining << 8) | {{(LEN_BITS-8){1'b0}}, b};
				len_left = len_left - 4'd1;
				if (len_left == '0)
					length_known();
			end
			PH_KEY: begin
				key_left = key_left - 3'd1;
				if (key_left == '0)
					header_known();
			end
			PH_PAYLOAD: begin
				remaining = remaining - LEN_BITS'(1);
				final_byte = (remaining == '0);
				if (final_byte)
					ph = PH_HDR0;
				if (opc == OP_PING)
					note_event(b, KIND_PING, final_byte);
				else
					note_event(b, KIND_DATA, final_byte & fin);
			end
			default: begin
				fin = b[7];
				opc = b[3:0];
				ph = PH_HDR1;
			end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// driver: one request per accept, model runs on accept
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (rx_valid && !rx_stall)
				parse_rx_byte(rx_byte);
			if (!rx_valid || !rx_stall) begin
				if (rx_pending.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
					rx_valid <= 1'b1;
					rx_byte <= rx_pending.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: compare against oldest predicted event, random stall
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				got = {data_byte, kind, msg_type, last};
				if (due_events.size() == 0) begin
					$display("%0t: unexpected result: data %h kind %0d type %0d last %0b",
						$time, got.data, got.kind, got.mtype, got.last);
					errors++;
				end else begin
					want = due_events.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected data %h kind %0d type %0d last %0b, %s",
							$time, want.data, want.kind, want.mtype, want.last, "actual:");
						$display("%0t:   actual data %h kind %0d type %0d last %0b",
							$time, got.data, got.kind, got.mtype, got.last);
						errors++;
					end
				end
			end
			res_stall <= !steady && ($urandom_range(99) < 28);
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] b);
		rx_pending.insert(rx_pending.size(), b);
		queued_bytes++;
	endtask

	task automatic queue_header(input logic fin_bit, input logic [2:0] rsv,
		input logic [3:0] op, input logic mask_bit, input logic [63:0] n,
		input len_form_t form);
		queue_byte({fin_bit, rsv, op});
		case (form)
		LEN_SHORT: begin
			queue_byte({mask_bit, n[6:0]});
		end
		LEN_EXT16: begin
			queue_byte({mask_bit, LEN7_EXT16});
			queue_byte(n[15:8]);
			queue_byte(n[7:0]);
		end
		default: begin
			queue_byte({mask_bit, LEN7_EXT64});
			for (int i = 7; i >= 0; i--)
				queue_byte(n[8*i +: 8]);
		end
		endcase
		if (mask_bit)
			repeat (KEY_BYTES) queue_byte(8'($urandom));
	endtask

	task automatic queue_frame(input logic fin_bit, input logic [3:0] op,
		input logic mask_bit, input int n, input len_form_t form);
		queue_header(fin_bit, 3'($urandom_range(7)), op, mask_bit, 64'(n), form);
		repeat (n) queue_byte(8'($urandom));
	endtask

	// wait until all requests are in, all events out, and the pipe drained
	task automatic settle();
		while (rx_pending.size() != 0 || rx_valid || due_events.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_enable(input logic v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		link_enabled = v;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int        random_start;
		int        r;
		int        n;
		logic [3:0] op;
		len_form_t form;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled after reset: even a close header is dropped
		queue_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd0, LEN_SHORT);
		queue_byte(8'h55);
		write_enable(1'b1);

		// directed: masked text with extreme bytes
		queue_header(1'b1, 3'b000, OP_TEXT, 1'b1, 64'd2, LEN_SHORT);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		// empty FIN frame gives end event
		queue_header(1'b1, 3'b000, OP_BINARY, 1'b0, 64'd0, LEN_SHORT);
		// empty non-FIN frame gives nothing
		queue_header(1'b0, 3'b000, OP_CONT, 1'b0, 64'd0, LEN_SHORT);
		// empty ping, then one-byte ping
		queue_header(1'b1, 3'b000, OP_PING, 1'b0, 64'd0, LEN_SHORT);
		queue_header(1'b1, 3'b000, OP_PING, 1'b0, 64'd1, LEN_SHORT);
		queue_byte(8'hA5);
		// pong with all RSV bits set passes as data
		queue_header(1'b1, 3'b111, OP_PONG, 1'b0, 64'd1, LEN_SHORT);
		queue_byte(8'h5A);
		// 16-bit length of zero
		queue_header(1'b1, 3'b000, OP_BINARY, 1'b0, 64'd0, LEN_EXT16);

		// mid-frame disable: parser state must hold across dropped bytes
		queue_byte({1'b1, 3'b000, OP_BINARY});
		queue_byte({1'b0, LEN7_EXT16});
		queue_byte(8'h00);
		write_enable(1'b0);
		repeat (5) queue_byte(8'($urandom));
		write_enable(1'b1);
		queue_byte(8'h03);
		repeat (3) queue_byte(8'($urandom));

		// size extremes, kept few
		queue_frame(1'b1, OP_BINARY, 1'b0, 5, LEN_EXT64);
		queue_frame(1'b1, OP_TEXT, 1'b1, 125, LEN_SHORT);
		queue_frame(1'b1, OP_CONT, 1'b0, 258, LEN_EXT16);

		// random frame mix, with a stretch where neither side idles
		random_start = queued_bytes;
		while (queued_bytes - random_start < 160) begin
			while (rx_pending.size() > 16)
				@(negedge clk);
			steady = (queued_bytes - random_start >= 30) &&
				(queued_bytes - random_start < 120);
			r = $urandom_range(99);
			if (r < 20)
				op = OP_TEXT;
			else if (r < 40)
				op = OP_BINARY;
			else if (r < 60)
				op = OP_CONT;
			else if (r < 75)
				op = OP_PING;
			else if (r < 85)
				op = OP_PONG;
			else begin
				do
					op = 4'($urandom_range(15));
				while (op == OP_CLOSE);
			end
			r = $urandom_range(99);
			if (r < 80) begin
				form = LEN_SHORT;
				n = $urandom_range(12);
			end else if (r < 85) begin
				form = LEN_SHORT;
				n = $urandom_range(125);
			end else if (r < 93) begin
				form = LEN_EXT16;
				n = $urandom_range(300);
			end else begin
				form = LEN_EXT64;
				n = $urandom_range(20);
			end
			queue_frame($urandom_range(99) < 70, op, 1'($urandom_range(1)), n, form);
		end
		steady = 1'b0;

		// close after masked 16-bit header; everything after is dropped
		queue_header(1'b1, 3'b000, OP_CLOSE, 1'b1, 64'd2, LEN_EXT16);
		queue_byte(8'($urandom));
		queue_byte(8'($urandom));
		queue_header(1'b1, 3'b000, OP_TEXT, 1'b0, 64'd1, LEN_SHORT);
		queue_byte(8'h41);

		settle();
		repeat (10) @(negedge clk);
		if (due_events.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_events.size());
			errors++;
		end
		if (errors == 0)
			$display("websocket_frame_deframer_top_test: PASS");
		else
			$display("websocket_frame_deframer_top_test: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("websocket_frame_deframer_top_test: FAIL");
		$finish;
	end

endmodule

/* websocket_frame_deframer_top.f */
+incdir+sv
sv/wsdf_pkg.sv
sv/websocket_frame_deframer_top.sv
tb/websocket_frame_deframer_top_test.sv
